// ----- hw/rtl/tpbc_pkg.sv -----
// Shared widths, band table, stage map and pipeline word type of the tuner PLL calculator.
package tpbc_pkg;

  localparam int unsigned RfW     = 32;
  localparam int unsigned CrysW   = 26;
  localparam int unsigned IfW     = 27;
  localparam int unsigned CfgW    = 27;
  localparam int unsigned MhzW    = 13;
  localparam int unsigned ProdW   = RfW + MhzW;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DivSelW = 3;
  localparam int unsigned SdmW    = 16;

  localparam int unsigned NumBands = 21;
  localparam int unsigned BandIdxW = 5;

  localparam logic [MhzW-1:0]    MhzScale = 13'd4295;
  localparam logic [RfW-1:0]     VcoLow   = 32'd1770000000;
  localparam logic [RfW-1:0]     VcoHigh  = 32'd3900000000;
  localparam logic [ByteW-1:0]   NintBias = 8'd13;
  localparam logic [ByteW-1:0]   MuxMask  = 8'hc3;
  localparam logic [SdmW-1:0]    SdmMsb   = 16'h8000;
  localparam logic [DivSelW-1:0] DivMax   = 3'd5;

  localparam logic [CrysW-1:0] CrystalReset  = 26'd28800000;
  localparam logic [IfW-1:0]   IfOffsetReset = 27'd2000000;

  localparam logic RegCrystal  = 1'b0;
  localparam logic RegIfOffset = 1'b1;

  localparam int unsigned DivSteps    = 32;
  localparam int unsigned SdmSteps    = 16;
  localparam int unsigned StFront     = 0;
  localparam int unsigned StSelect    = 1;
  localparam int unsigned StDividend  = 2;
  localparam int unsigned StDivFirst  = 3;
  localparam int unsigned StMul       = StDivFirst + DivSteps;
  localparam int unsigned StRem       = StMul + 1;
  localparam int unsigned StAdjust    = StRem + 1;
  localparam int unsigned StSdmFirst  = StAdjust + 1;
  localparam int unsigned NumStages   = StSdmFirst + SdmSteps;

  localparam logic [MhzW-1:0] BandMhz [NumBands] = '{
    13'd0,   13'd50,  13'd55,  13'd60,  13'd65,  13'd70,  13'd75,
    13'd80,  13'd90,  13'd100, 13'd110, 13'd120, 13'd140, 13'd180,
    13'd220, 13'd250, 13'd280, 13'd310, 13'd450, 13'd588, 13'd650
  };

  localparam logic BandOd [NumBands] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  localparam logic [ByteW-1:0] BandMux [NumBands] = '{
    8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02,
    8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02,
    8'h02, 8'h02, 8'h02, 8'h41, 8'h41, 8'h40, 8'h40
  };

  localparam logic [ByteW-1:0] BandTf [NumBands] = '{
    8'hdf, 8'hbe, 8'h8b, 8'h7b, 8'h69, 8'h58, 8'h44,
    8'h44, 8'h34, 8'h34, 8'h24, 8'h24, 8'h14, 8'h13,
    8'h13, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [MhzW-1:0]    mhz;
    logic [RfW-1:0]     lo;
    logic               od;
    logic [ByteW-1:0]   mux;
    logic [ByteW-1:0]   tf;
    logic [DivSelW-1:0] div;
    logic [RfW-1:0]     vco;
    logic [RfW-1:0]     num;
    logic [CrysW-1:0]   part;
    logic [ByteW-1:0]   quo;
    logic [SdmW-1:0]    sdm;
    logic               fdis;
    logic               act;
  } tpbc_item_t;

endpackage

// ----- hw/rtl/tuner_pll_and_band_calculator.sv -----
// Top level: pipelined tracking-filter band lookup and LO PLL word calculator.
// The pipeline has 54 register stages from input to output.
// Throughput: one word per cycle while the output is not stalled; 32 divider stages, 16 sigma-delta stages and six
// setup and finishing stages set the depth.
// A stall on a valid output word freezes the whole pipeline and the input; bubbles move with the words.
// Reset clears all valid bits and loads the default crystal and IF offset.
module tuner_pll_and_band_calculator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tpbc_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tpbc_pkg::RfW-1:0]         rf_frequency_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             band_open_drain_o,
  output logic [tpbc_pkg::ByteW-1:0]       rf_mux_polymux_o,
  output logic [tpbc_pkg::ByteW-1:0]       tf_band_o,
  output logic [tpbc_pkg::DivSelW-1:0]     vco_divider_o,
  output logic [tpbc_pkg::ByteW-1:0]       pll_integer_word_o,
  output logic [tpbc_pkg::SdmW-1:0]        sdm_word_o,
  output logic                             frac_disabled_o
);

  localparam int unsigned Last = tpbc_pkg::NumStages - 1;

  logic [tpbc_pkg::CrysW-1:0] crystal_q;
  logic [tpbc_pkg::IfW-1:0]   if_offset_q;
  logic [Last:0]              v_q, v_d;
  tpbc_pkg::tpbc_item_t       st_q [tpbc_pkg::NumStages];
  tpbc_pkg::tpbc_item_t       st_d [tpbc_pkg::NumStages];
  logic                       adv;
  logic [tpbc_pkg::RfW-1:0]   ref_bias;
  logic [tpbc_pkg::RfW-1:0]   ref_half;

  assign adv        = !(v_q[Last] && out_stall_i);
  assign in_stall_o = !adv;
  assign v_d        = {v_q[Last-1:0], in_valid_i};
  assign ref_bias   = 32'(crystal_q[tpbc_pkg::CrysW-1:17]);
  assign ref_half   = 32'(crystal_q[tpbc_pkg::CrysW-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q   <= tpbc_pkg::CrystalReset;
      if_offset_q <= tpbc_pkg::IfOffsetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpbc_pkg::RegCrystal:  crystal_q   <= cfg_wdata_i[tpbc_pkg::CrysW-1:0];
        tpbc_pkg::RegIfOffset: if_offset_q <= cfg_wdata_i[tpbc_pkg::IfW-1:0];
        default: ;
      endcase
    end
  end

  // front: MHz estimate and LO sum
  always_comb begin
    logic [tpbc_pkg::ProdW-1:0] prod;
    prod = tpbc_pkg::ProdW'(rf_frequency_i) * tpbc_pkg::ProdW'(tpbc_pkg::MhzScale);
    st_d[tpbc_pkg::StFront]     = '0;
    st_d[tpbc_pkg::StFront].mhz = prod[tpbc_pkg::ProdW-1:tpbc_pkg::RfW];
    st_d[tpbc_pkg::StFront].lo  = rf_frequency_i + 32'(if_offset_q);
  end

  // select: band and VCO divider
  always_comb begin
    logic [tpbc_pkg::BandIdxW-1:0] band;
    logic [tpbc_pkg::DivSelW-1:0]  dsel;
    logic [4:0]                    hit;
    logic [tpbc_pkg::RfW-1:0]      shifted;
    band = '0;
    for (int i = 1; i < tpbc_pkg::NumBands; i++) begin
      if (st_q[tpbc_pkg::StFront].mhz >= tpbc_pkg::BandMhz[i]) begin
        band = tpbc_pkg::BandIdxW'(i);
      end
    end
    for (int i = 0; i < 5; i++) begin
      shifted = st_q[tpbc_pkg::StFront].lo << (i + 1);
      hit[i]  = (shifted >= tpbc_pkg::VcoLow) && (shifted <= tpbc_pkg::VcoHigh);
    end
    dsel = tpbc_pkg::DivMax;
    for (int i = 4; i >= 0; i--) begin
      if (hit[i]) begin
        dsel = tpbc_pkg::DivSelW'(i);
      end
    end
    st_d[tpbc_pkg::StSelect]     = st_q[tpbc_pkg::StFront];
    st_d[tpbc_pkg::StSelect].od  = tpbc_pkg::BandOd[band];
    st_d[tpbc_pkg::StSelect].mux = tpbc_pkg::BandMux[band] & tpbc_pkg::MuxMask;
    st_d[tpbc_pkg::StSelect].tf  = tpbc_pkg::BandTf[band];
    st_d[tpbc_pkg::StSelect].div = dsel;
    st_d[tpbc_pkg::StSelect].vco = st_q[tpbc_pkg::StFront].lo << (dsel + 3'd1);
  end

  // dividend for the integer divider
  always_comb begin
    st_d[tpbc_pkg::StDividend]      = st_q[tpbc_pkg::StSelect];
    st_d[tpbc_pkg::StDividend].num  = st_q[tpbc_pkg::StSelect].vco + ref_bias;
    st_d[tpbc_pkg::StDividend].part = '0;
    st_d[tpbc_pkg::StDividend].quo  = '0;
  end

  // restoring division, one quotient bit per stage, low byte kept
  always_comb begin
    logic [tpbc_pkg::CrysW:0] trial;
    logic                     qbit;
    for (int k = tpbc_pkg::StDivFirst; k < tpbc_pkg::StMul; k++) begin
      trial = {st_q[k-1].part, st_q[k-1].num[tpbc_pkg::RfW-1]};
      qbit  = trial >= {1'b0, crystal_q};
      st_d[k]      = st_q[k-1];
      st_d[k].num  = st_q[k-1].num << 1;
      st_d[k].quo  = {st_q[k-1].quo[tpbc_pkg::ByteW-2:0], qbit};
      st_d[k].part = qbit ? tpbc_pkg::CrysW'(trial - {1'b0, crystal_q})
                          : trial[tpbc_pkg::CrysW-1:0];
    end
  end

  always_comb begin
    logic [tpbc_pkg::CrysW+tpbc_pkg::ByteW-1:0] mprod;
    mprod = (tpbc_pkg::CrysW+tpbc_pkg::ByteW)'(crystal_q)
          * (tpbc_pkg::CrysW+tpbc_pkg::ByteW)'(st_q[tpbc_pkg::StMul-1].quo);
    st_d[tpbc_pkg::StMul]     = st_q[tpbc_pkg::StMul-1];
    st_d[tpbc_pkg::StMul].num = mprod[tpbc_pkg::RfW-1:0];
  end

  always_comb begin
    logic [tpbc_pkg::RfW-1:0]   rem;
    logic [tpbc_pkg::ByteW-1:0] n;
    rem = st_q[tpbc_pkg::StMul].vco - st_q[tpbc_pkg::StMul].num;
    n   = st_q[tpbc_pkg::StMul].quo - tpbc_pkg::NintBias;
    st_d[tpbc_pkg::StRem]      = st_q[tpbc_pkg::StMul];
    st_d[tpbc_pkg::StRem].num  = rem;
    st_d[tpbc_pkg::StRem].fdis = rem == '0;
    st_d[tpbc_pkg::StRem].act  = rem != '0;
    st_d[tpbc_pkg::StRem].quo  = {n[1:0], n[tpbc_pkg::ByteW-1:2]};
  end

  always_comb begin
    st_d[tpbc_pkg::StAdjust]     = st_q[tpbc_pkg::StRem];
    st_d[tpbc_pkg::StAdjust].num = st_q[tpbc_pkg::StRem].num + ref_bias;
    st_d[tpbc_pkg::StAdjust].sdm = '0;
  end

  // sigma-delta word, one compare-subtract per stage
  always_comb begin
    logic [tpbc_pkg::RfW-1:0] step;
    logic [tpbc_pkg::RfW-1:0] diff;
    for (int k = tpbc_pkg::StSdmFirst; k < tpbc_pkg::NumStages; k++) begin
      step    = ref_half >> (k - tpbc_pkg::StSdmFirst);
      diff    = st_q[k-1].num - step;
      st_d[k] = st_q[k-1];
      if (st_q[k-1].act && (st_q[k-1].num >= step)) begin
        st_d[k].sdm = st_q[k-1].sdm | (tpbc_pkg::SdmMsb >> (k - tpbc_pkg::StSdmFirst));
        st_d[k].num = diff;
        st_d[k].act = diff != '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  assign out_valid_o        = v_q[Last];
  assign band_open_drain_o  = st_q[Last].od;
  assign rf_mux_polymux_o   = st_q[Last].mux;
  assign tf_band_o          = st_q[Last].tf;
  assign vco_divider_o      = st_q[Last].div;
  assign pll_integer_word_o = st_q[Last].quo;
  assign sdm_word_o         = st_q[Last].sdm;
  assign frac_disabled_o    = st_q[Last].fdis;

`ifndef SYNTHESIS
  a_fdis_no_sdm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frac_disabled_o) |-> (sdm_word_o == '0))
    else $error("sdm word set with fractional mode off");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (vco_divider_o <= tpbc_pkg::DivMax))
    else $error("vco divider out of range");

  a_od_low_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && band_open_drain_o) |-> (tf_band_o >= 8'h58))
    else $error("open-drain band with high-band filter byte");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted word missing from first stage");
`endif

endmodule

// ----- test/tb_tuner_pll_and_band_calculator.sv -----
// Self-checking testbench for the tuner PLL and band calculator with a word-level scoreboard.
`timescale 1ns / 1ps

module tb_tuner_pll_and_band_calculator;

  typedef struct packed {
    logic        od;
    logic [7:0]  mux;
    logic [7:0]  tf;
    logic [2:0]  div;
    logic [7:0]  word;
    logic [15:0] sdm;
    logic        fdis;
  } tuning_t;

  class tuner_words_board;
    logic [25:0]  crystal;
    logic [26:0]  if_off;
    tuning_t      pending_words[$];
    int unsigned  errors;

    function new();
      crystal = 26'd28800000;
      if_off  = 27'd2000000;
      errors  = 0;
    endfunction

    // {floor MHz, open drain, mux byte, tf byte}
    function logic [26:0] band_row(int b);
      case (b)
        0:       return {10'd0,   1'b1, 8'h02, 8'hdf};
        1:       return {10'd50,  1'b1, 8'h02, 8'hbe};
        2:       return {10'd55,  1'b1, 8'h02, 8'h8b};
        3:       return {10'd60,  1'b1, 8'h02, 8'h7b};
        4:       return {10'd65,  1'b1, 8'h02, 8'h69};
        5:       return {10'd70,  1'b1, 8'h02, 8'h58};
        6:       return {10'd75,  1'b0, 8'h02, 8'h44};
        7:       return {10'd80,  1'b0, 8'h02, 8'h44};
        8:       return {10'd90,  1'b0, 8'h02, 8'h34};
        9:       return {10'd100, 1'b0, 8'h02, 8'h34};
        10:      return {10'd110, 1'b0, 8'h02, 8'h24};
        11:      return {10'd120, 1'b0, 8'h02, 8'h24};
        12:      return {10'd140, 1'b0, 8'h02, 8'h14};
        13:      return {10'd180, 1'b0, 8'h02, 8'h13};
        14:      return {10'd220, 1'b0, 8'h02, 8'h13};
        15:      return {10'd250, 1'b0, 8'h02, 8'h11};
        16:      return {10'd280, 1'b0, 8'h02, 8'h00};
        17:      return {10'd310, 1'b0, 8'h41, 8'h00};
        18:      return {10'd450, 1'b0, 8'h41, 8'h00};
        19:      return {10'd588, 1'b0, 8'h40, 8'h00};
        default: return {10'd650, 1'b0, 8'h40, 8'h00};
      endcase
    endfunction

    function void write_reg(logic idx, logic [26:0] data);
      if (idx == tpbc_pkg::RegCrystal) crystal = data[25:0];
      else if_off = data;
    endfunction

    function tuning_t predict_tuning(logic [31:0] rf);
      logic [63:0] prod;
      logic [31:0] mhz;
      logic [31:0] lo;
      logic [31:0] vco;
      logic [31:0] ref_full;
      logic [31:0] ref_half;
      logic [31:0] quo;
      logic [31:0] rem;
      logic [31:0] step;
      logic [26:0] row;
      logic [7:0]  nint;
      logic [7:0]  n;
      int          b;
      int          d;
      int          k;
      tuning_t     t;
      prod = {32'd0, rf} * 64'd4295;
      mhz  = prod[63:32];
      for (b = 0; b < 20; b++) begin
        row = band_row(b + 1);
        if (mhz < {22'd0, row[26:17]}) break;
      end
      row   = band_row(b);
      t.od  = row[16];
      t.mux = row[15:8] & 8'hc3;
      t.tf  = row[7:0];
      lo = rf + {5'd0, if_off};
      for (d = 0; d < 5; d++) begin
        vco = lo << (d + 1);
        if (vco >= 32'd1770000000 && vco <= 32'd3900000000) break;
      end
      vco      = lo << (d + 1);
      ref_full = {6'd0, crystal};
      ref_half = ref_full >> 1;
      quo      = (ref_full == 32'd0) ? 32'hffff_ffff : (vco + (ref_half >> 16)) / ref_full;
      nint     = quo[7:0];
      rem      = vco - ref_full * {24'd0, nint};
      n        = nint - 8'd13;
      t.div    = d[2:0];
      t.word   = {n[1:0], n[7:2]};
      t.sdm    = 16'd0;
      t.fdis   = 1'b0;
      if (rem == 32'd0) begin
        t.fdis = 1'b1;
      end else begin
        rem = rem + (ref_half >> 16);
        for (k = 0; k < 16; k++) begin
          step = ref_half >> k;
          if (rem >= step) begin
            t.sdm[15-k] = 1'b1;
            rem = rem - step;
            if (rem == 32'd0) break;
          end
        end
      end
      return t;
    endfunction

    function void note_frequency(logic [31:0] rf);
      pending_words.push_back(predict_tuning(rf));
    endfunction

    function void check_words(tuning_t got);
      tuning_t want;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: od=%0d mux=%h tf=%h div=%0d word=%h sdm=%h fdis=%0d",
                   got.od, got.mux, got.tf, got.div, got.word, got.sdm, got.fdis);
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: od=%0d mux=%h tf=%h div=%0d word=%h sdm=%h fdis=%0d",
                   want.od, want.mux, want.tf, want.div, want.word, want.sdm, want.fdis);
          $display("         got: od=%0d mux=%h tf=%h div=%0d word=%h sdm=%h fdis=%0d",
                   got.od, got.mux, got.tf, got.div, got.word, got.sdm, got.fdis);
        end
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic                             cfg_idx_i;
  logic [tpbc_pkg::CfgW-1:0]        cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [tpbc_pkg::RfW-1:0]         rf_frequency_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic                             band_open_drain_o;
  logic [tpbc_pkg::ByteW-1:0]       rf_mux_polymux_o;
  logic [tpbc_pkg::ByteW-1:0]       tf_band_o;
  logic [tpbc_pkg::DivSelW-1:0]     vco_divider_o;
  logic [tpbc_pkg::ByteW-1:0]       pll_integer_word_o;
  logic [tpbc_pkg::SdmW-1:0]        sdm_word_o;
  logic                             frac_disabled_o;

  tuner_words_board board = new();

  logic [25:0] cur_crystal = 26'd28800000;
  logic [26:0] cur_if_off  = 27'd2000000;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          mode_left   = 0;
  int          run_left    = 0;

  tuner_pll_and_band_calculator DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rf_frequency_i     (rf_frequency_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .band_open_drain_o  (band_open_drain_o),
    .rf_mux_polymux_o   (rf_mux_polymux_o),
    .tf_band_o          (tf_band_o),
    .vco_divider_o      (vco_divider_o),
    .pll_integer_word_o (pll_integer_word_o),
    .sdm_word_o         (sdm_word_o),
    .frac_disabled_o    (frac_disabled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd20 * 64'd400000);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_words({band_open_drain_o, rf_mux_polymux_o, tf_band_o, vco_divider_o,
                           pll_integer_word_o, sdm_word_o, frac_disabled_o});
      if (cfg_we_i) board.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) board.note_frequency(rf_frequency_i);
    end
  end

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left    <= $urandom_range(1, 30);
          out_stall_i <= ~out_stall_i;
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  task automatic write_reg(input logic idx, input logic [26:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_tuning(input logic [26:0] xtal_data, input logic [26:0] if_data);
    write_reg(tpbc_pkg::RegCrystal, xtal_data);
    write_reg(tpbc_pkg::RegIfOffset, if_data);
    cur_crystal = xtal_data[25:0];
    cur_if_off  = if_data;
  endtask

  task automatic feed(input logic [31:0] f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i     <= 1'b0;
        rf_frequency_i <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    rf_frequency_i <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_frequency();
    logic [63:0] wide;
    logic [26:0] row;
    logic [31:0] f;
    int          sel;
    int          d;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      f = $urandom_range(0, 1800000000);
    end else if (sel < 60) begin
      row  = board.band_row($urandom_range(1, 20));
      wide = ({54'd0, row[26:17]} << 32) / 64'd4295;
      f    = wide[31:0] + $urandom_range(0, 600) - 32'd300;
    end else if (sel < 75) begin
      d    = $urandom_range(0, 4);
      wide = {38'd0, cur_crystal} * 64'($urandom_range(62, 135));
      f    = (wide[31:0] >> (d + 1)) - {5'd0, cur_if_off};
    end else begin
      f = $urandom;
    end
    return f;
  endfunction

  logic [31:0] directed_words [17] = '{
    32'd0, 32'hffff_ffff, 32'd1, 32'h8000_0000, 32'd49999000, 32'd50005000,
    32'd74990000, 32'd75010000, 32'd280000000, 32'd588010000, 32'd649990000,
    32'd650010000, 32'd1000000000, 32'd1438000000, 32'd88000000, 32'd24000000,
    32'd3000000000
  };

  initial begin
    logic [26:0] xtal_data;
    logic [26:0] if_data;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= tpbc_pkg::RegCrystal;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    rf_frequency_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) feed(directed_words[i]);
    feed(32'hfff0_0000);
    drain();

    // zero crystal: quotient saturates, every sigma-delta step fires for a nonzero remainder
    set_tuning(27'd0, 27'd2000000);
    feed(32'd1438000000);
    feed(32'd0);
    feed(32'hffe1_7b80);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin xtal_data = 27'd12000000;  if_data = 27'd0; end
        1: begin xtal_data = 27'd64000000;  if_data = 27'd100000000; end
        2: begin xtal_data = 27'd1;         if_data = 27'h7ff_ffff; end
        3: begin
          xtal_data = 27'h3ff_ffff;
          if_data   = 27'($urandom_range(0, 100000000));
        end
        4: begin
          xtal_data = 27'($urandom_range(12000000, 64000000));
          if_data   = 27'($urandom_range(0, 100000000));
        end
        5: begin xtal_data = {1'b1, 26'd28800000}; if_data = 27'd4570000; end
        6: begin xtal_data = 27'($urandom); if_data = 27'($urandom); end
        default: begin xtal_data = 27'd16000000; if_data = 27'd3570000; end
      endcase
      set_tuning(xtal_data, if_data);
      repeat (80) feed(random_frequency());
      drain();
    end

    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
